[rtl/fhs_pkg.sv]
package fhs_pkg;

   localparam int VERT_W = 16;
   localparam int HASH_W = 28;

   localparam logic [HASH_W-1:0] HASH_K_LO  = HASH_W'(31);
   localparam logic [HASH_W-1:0] HASH_K_HI  = HASH_W'(3023);
   localparam logic [HASH_W-1:0] HASH_K_MID = HASH_W'(1783);

   typedef enum logic {
      CMD_TOGGLE   = 1'b0,
      CMD_GET_NEXT = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_REMOVED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_RETURNED = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic [VERT_W-1:0] lo;
      logic [VERT_W-1:0] hi;
      logic [VERT_W-1:0] mid;
   } face_type;

endpackage

[rtl/fhs_if.sv]
interface fhs_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] vert_a;
   logic [15:0] vert_b;
   logic [15:0] vert_c;

   modport source (output valid, command, vert_a, vert_b, vert_c, input ready);
   modport sink (input valid, command, vert_a, vert_b, vert_c, output ready);
endinterface

interface fhs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] face_lo;
   logic [15:0] face_hi;
   logic [15:0] face_mid;
   logic [31:0] insert_total;
   logic [31:0] collision_total;

   modport source (output valid, status, face_lo, face_hi, face_mid, insert_total,
                   collision_total, input ready);
   modport sink (input valid, status, face_lo, face_hi, face_mid, insert_total,
                 collision_total, output ready);
endinterface

[rtl/toggle_face_hash_set_top.sv]
// Set of triangle faces in a chained hash table held in block RAM. After reset the
// bucket heads are cleared one per cycle, so no transaction is taken until every
// bucket head is cleared. The hash registers the three products and then the bucket
// when BUCKETS is a power of two, with a reciprocal product register between the two
// otherwise, and every chain entry that is compared passes through a read state and a
// compare state. A get_next first reads the newest face before it is hashed and
// removed, and a get_next on an empty set answers without a hash. The bucket chain
// walk through the face and link memories sets how long a transaction takes. One
// transaction is in work at a time, and the next is taken while a result still waits.
module toggle_face_hash_set_top
   import fhs_pkg::*;
#(
   parameter int BUCKETS  = 256,
   parameter int CAPACITY = 1024
) (
   input logic      clock,
   input logic      reset,
   fhs_req_if.sink  req_ch,
   fhs_rsp_if.source rsp_ch
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IW = $clog2(CAPACITY + 1);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [IW-1:0] NONE = IW'(CAPACITY);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_GFACE, S_HASH, S_HEAD, S_READ, S_CMP,
      S_UNLINK, S_ALLOC, S_INS1, S_INS2, S_DONE
   } state_type;

   state_type     state_ff;
   logic [BW-1:0] clr_ff;
   face_type      face_ff;
   logic          cmd_ff;
   logic [BW-1:0] bucket_ff;
   logic [IW-1:0] head_ff, cur_ff, prev_ff, link_ff, ent_ff, newest_ff;
   logic [IW-1:0] fresh_ff, free_cnt_ff;
   logic [31:0]   ins_ff, col_ff;
   status_type    status_ff;
   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   face_type      rsp_face_ff;
   logic [31:0]   rsp_ins_ff, rsp_col_ff;

   face_type      canon;
   logic          hash_start, hash_done;
   logic [BW-1:0] hash_bucket;
   logic [IW-1:0] free_top;
   logic          table_full;

   logic [47:0]   face_rd;
   logic [AW-1:0] face_raddr;
   logic          face_we;
   logic [IW-1:0] link_rd, head_rd, older_rd, newer_rd;
   logic [AW-1:0] free_rd;
   logic          link_we, head_we, older_we, newer_we, free_we;
   logic [AW-1:0] link_wa, older_wa, newer_wa;
   logic [BW-1:0] head_wa, head_ra;
   logic [IW-1:0] link_wd, head_wd, older_wd, newer_wd;

   always_comb begin
      logic [VERT_W-1:0] a, b, c, t;
      a = req_ch.vert_a;
      b = req_ch.vert_b;
      c = req_ch.vert_c;
      t = '0;
      if (b < a) begin
         t = a; a = b; b = t;
      end
      if (c < a) begin
         t = a; a = c; c = t;
      end
      if (b < c) begin
         t = b; b = c; c = t;
      end
      canon.lo  = a;
      canon.hi  = b;
      canon.mid = c;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign hash_start = ((state_ff == S_IDLE) && req_ch.valid &&
                        (req_ch.command == CMD_TOGGLE)) || (state_ff == S_GFACE);
   assign free_top   = free_cnt_ff - IW'(1);
   assign table_full = (fresh_ff == NONE) && (free_cnt_ff == '0);

   fhs_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .face   ((state_ff == S_GFACE) ? face_type'(face_rd) : canon),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   always_comb begin
      face_raddr = (state_ff == S_IDLE) ? newest_ff[AW-1:0] : cur_ff[AW-1:0];
      face_we    = (state_ff == S_INS1);
      head_ra    = hash_bucket;
      link_we = 1'b0; link_wa = prev_ff[AW-1:0]; link_wd = link_ff;
      head_we = 1'b0; head_wa = bucket_ff;       head_wd = link_ff;
      older_we = 1'b0; older_wa = newer_rd[AW-1:0]; older_wd = older_rd;
      newer_we = 1'b0; newer_wa = older_rd[AW-1:0]; newer_wd = newer_rd;
      free_we = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            head_wd = NONE;
         end
         S_UNLINK: begin
            link_we  = (prev_ff != NONE);
            head_we  = (prev_ff == NONE);
            older_we = (newer_rd != NONE);
            newer_we = (older_rd != NONE);
            free_we  = 1'b1;
         end
         S_INS1: begin
            link_we  = 1'b1;
            link_wa  = ent_ff[AW-1:0];
            link_wd  = head_ff;
            head_we  = 1'b1;
            head_wd  = ent_ff;
            older_we = 1'b1;
            older_wa = ent_ff[AW-1:0];
            older_wd = newest_ff;
            newer_we = 1'b1;
            newer_wa = ent_ff[AW-1:0];
            newer_wd = NONE;
         end
         S_INS2: begin
            newer_we = (newest_ff != NONE);
            newer_wa = newest_ff[AW-1:0];
            newer_wd = ent_ff;
         end
         default: begin
         end
      endcase
   end

   fhs_ram #(.WIDTH(48), .DEPTH(CAPACITY)) u_face_ram (
      .clock(clock), .wr_en(face_we), .wr_addr(ent_ff[AW-1:0]), .wr_data(face_ff),
      .rd_addr(face_raddr), .rd_data(face_rd));
   fhs_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr(cur_ff[AW-1:0]), .rd_data(link_rd));
   fhs_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_head_ram (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(head_ra), .rd_data(head_rd));
   fhs_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_older_ram (
      .clock(clock), .wr_en(older_we), .wr_addr(older_wa), .wr_data(older_wd),
      .rd_addr(cur_ff[AW-1:0]), .rd_data(older_rd));
   fhs_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_newer_ram (
      .clock(clock), .wr_en(newer_we), .wr_addr(newer_wa), .wr_data(newer_wd),
      .rd_addr(cur_ff[AW-1:0]), .rd_data(newer_rd));
   fhs_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
      .clock(clock), .wr_en(free_we), .wr_addr(free_cnt_ff[AW-1:0]),
      .wr_data(cur_ff[AW-1:0]), .rd_addr(free_top[AW-1:0]), .rd_data(free_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         newest_ff    <= NONE;
         fresh_ff     <= '0;
         free_cnt_ff  <= '0;
         ins_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + BW'(1);
               if (clr_ff == BW'(BUCKETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_ch.valid) begin
                  cmd_ff <= req_ch.command;
                  if (req_ch.command == CMD_TOGGLE) begin
                     face_ff  <= canon;
                     state_ff <= S_HASH;
                  end else if (newest_ff != NONE) begin
                     cur_ff   <= newest_ff;
                     state_ff <= S_GFACE;
                  end else begin
                     face_ff   <= '0;
                     status_ff <= ST_EMPTY;
                     state_ff  <= S_DONE;
                  end
               end
            end
            S_GFACE: begin
               face_ff  <= face_type'(face_rd);
               state_ff <= S_HASH;
            end
            S_HASH: begin
               if (hash_done) begin
                  bucket_ff <= hash_bucket;
                  state_ff  <= S_HEAD;
               end
            end
            S_HEAD: begin
               head_ff <= head_rd;
               cur_ff  <= head_rd;
               prev_ff <= NONE;
               state_ff <= (head_rd == NONE) ? S_ALLOC : S_READ;
            end
            S_READ: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               link_ff <= link_rd;
               if (face_type'(face_rd) == face_ff) begin
                  state_ff <= S_UNLINK;
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= link_rd;
                  state_ff <= (link_rd == NONE) ? S_ALLOC : S_READ;
               end
            end
            S_UNLINK: begin
               if (newest_ff == cur_ff) begin
                  newest_ff <= older_rd;
               end
               free_cnt_ff <= free_cnt_ff + IW'(1);
               status_ff <= (cmd_ff == CMD_GET_NEXT) ? ST_RETURNED : ST_REMOVED;
               state_ff  <= S_DONE;
            end
            S_ALLOC: begin
               if (table_full) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  if (free_cnt_ff != '0) begin
                     ent_ff      <= IW'(free_rd);
                     free_cnt_ff <= free_top;
                  end else begin
                     ent_ff   <= fresh_ff;
                     fresh_ff <= fresh_ff + IW'(1);
                  end
                  state_ff <= S_INS1;
               end
            end
            S_INS1: begin
               ins_ff <= ins_ff + 32'd1;
               if (head_ff != NONE) begin
                  col_ff <= col_ff + 32'd1;
               end
               state_ff <= S_INS2;
            end
            S_INS2: begin
               newest_ff <= ent_ff;
               status_ff <= ST_INSERTED;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_face_ff   <= face_ff;
                  rsp_ins_ff    <= ins_ff;
                  rsp_col_ff    <= col_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.face_lo         = rsp_face_ff.lo;
   assign rsp_ch.face_hi         = rsp_face_ff.hi;
   assign rsp_ch.face_mid        = rsp_face_ff.mid;
   assign rsp_ch.insert_total    = rsp_ins_ff;
   assign rsp_ch.collision_total = rsp_col_ff;
endmodule

[rtl/fhs_ram.sv]
module fhs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/fhs_hash.sv]
module fhs_hash
   import fhs_pkg::*;
#(
   parameter int BUCKETS = 256,
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  face_type      face,
   output logic          done,
   output logic [BW-1:0] bucket
);
   logic [HASH_W-1:0] p_lo_ff, p_hi_ff, p_mid_ff;
   logic              run_ff;
   logic [HASH_W-1:0] mix;

   always_ff @(posedge clock) begin
      if (start) begin
         p_lo_ff  <= HASH_W'(face.lo) * HASH_K_LO;
         p_hi_ff  <= HASH_W'(face.hi) * HASH_K_HI;
         p_mid_ff <= HASH_W'(face.mid) * HASH_K_MID;
      end
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= start;
      end
   end

   assign mix = p_lo_ff ^ p_hi_ff ^ p_mid_ff;

   generate
      if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
         logic [BW-1:0] bucket_ff;
         logic          done_ff;
         always_ff @(posedge clock) begin
            if (run_ff) begin
               bucket_ff <= mix[BW-1:0] & BW'(BUCKETS - 1);
            end
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= run_ff;
            end
         end
         assign done   = done_ff;
         assign bucket = bucket_ff;
      end else begin : g_recip
         localparam int RS = HASH_W + BW;
         localparam logic [HASH_W:0] RECIP =
            (HASH_W+1)'(((64'd1 << RS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
         logic [2*HASH_W:0] prod_ff;
         logic [HASH_W-1:0] quot, rem;
         logic [BW-1:0]     bucket_ff;
         logic              step_ff, done_ff;
         always_comb begin
            quot = HASH_W'(prod_ff >> RS);
            rem  = mix - quot * HASH_W'(BUCKETS);
         end
         always_ff @(posedge clock) begin
            if (run_ff) begin
               prod_ff <= (2*HASH_W+1)'(mix) * (2*HASH_W+1)'(RECIP);
            end
            if (step_ff) begin
               bucket_ff <= rem[BW-1:0];
            end
            if (reset) begin
               step_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               step_ff <= run_ff;
               done_ff <= step_ff;
            end
         end
         assign done   = done_ff;
         assign bucket = bucket_ff;
      end
   endgenerate
endmodule
